// ===== rtl/tfl_pkg.sv =====
package tfl_pkg;

	// default number of factor stages, and the table depth it is clamped to
	localparam int FACTOR_STAGES_DEF = 6;
	localparam int TABLE_LEN         = 8;
	localparam int STAGE_W           = $clog2(TABLE_LEN);

	// widths
	localparam int ARG_W  = 64;
	localparam int LOG_W  = 32;
	localparam int C_W    = 36;   // running product, at most ten in Q4.32
	localparam int SLOG_W = 23;   // stage logarithm magnitude, Q8.24 scale held in 23 bits

	// Q32.32 constants
	localparam logic [ARG_W-1:0] ONE_Q32 = 64'h0000_0001_0000_0000;
	localparam logic [ARG_W-1:0] TEN_Q32 = 64'h0000_000A_0000_0000;

	// one decade step in Q8.24
	localparam logic [LOG_W-1:0] DECADE_STEP = 32'h0100_0000;

	// byte-wise divide by ten: floor(t/10) = (t * DIV10_RECIP) >> 16 for t < 2560
	localparam logic [12:0] DIV10_RECIP = 13'd6554;
	localparam logic [11:0] DIV10_CONST = 12'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_DIV,
		ST_MLO,
		ST_MHI,
		ST_CMP,
		ST_OUT
	} state_t;

	// factors 2, 1.1, 1.01, ... in Q2.30
	function automatic logic [31:0] stage_factor(input logic [STAGE_W-1:0] idx);
		logic [31:0] f;
		case (idx)
			3'd0:    f = 32'd2147483648;
			3'd1:    f = 32'd1181116006;
			3'd2:    f = 32'd1084479242;
			3'd3:    f = 32'd1074815566;
			3'd4:    f = 32'd1073849198;
			3'd5:    f = 32'd1073752561;
			3'd6:    f = 32'd1073742898;
			default: f = 32'd1073741931;
		endcase
		return f;
	endfunction

	// log10 of each factor in Q8.24
	function automatic logic [SLOG_W-1:0] stage_log(input logic [STAGE_W-1:0] idx);
		logic [SLOG_W-1:0] l;
		case (idx)
			3'd0:    l = 23'd5050445;
			3'd1:    l = 23'd694454;
			3'd2:    l = 23'd72501;
			3'd3:    l = 23'd7283;
			3'd4:    l = 23'd729;
			3'd5:    l = 23'd73;
			3'd6:    l = 23'd7;
			default: l = 23'd1;
		endcase
		return l;
	endfunction

endpackage

// ===== rtl/tfl_mul.sv =====
// registered 32x32 unsigned multiplier, shared by both halves of a factor step
module tfl_mul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= 64'(a) * 64'(b);
		end
	end

	assign p = p_q;

endmodule

// ===== rtl/table_factor_log10.sv =====
// table_factor_log10: base-10 logarithm of an unsigned Q32.32 argument, returned as signed
// Q8.24 in m_axis_tdata. m_axis_tuser is 1 when the argument was zero (tdata is then 0).
// The argument is first brought into the decade [1,10]. Each division by ten is one check
// plus eight byte-wide quotient digits; each multiplication by ten is done in the check
// state itself. There are at most nine divisions or ten multiplications. The fraction
// is then built from FACTOR_STAGES table factors (2, 1.1, 1.01, ...). Every trial
// multiplication runs on the one shared 32x32 multiplier in three steps: low half, high
// half, then add and compare. A stage runs one trial more than the factors it accepts.
// A zero argument skips the scaling and the factor stages. The input is taken only
// between items. A finished result sits in the output register, so the next item can
// be accepted while it waits.
module table_factor_log10 #(
	parameter int FACTOR_STAGES = tfl_pkg::FACTOR_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] arg_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] log_result
	output logic        m_axis_tuser    // [0] status
);

	// stage count clamped to the table
	localparam int STAGE_N = (FACTOR_STAGES > tfl_pkg::TABLE_LEN) ?
		tfl_pkg::TABLE_LEN : FACTOR_STAGES;
	localparam logic [tfl_pkg::STAGE_W-1:0] STAGE_LAST = tfl_pkg::STAGE_W'(STAGE_N - 1);

	tfl_pkg::state_t state_q, state_d;

	logic [tfl_pkg::ARG_W-1:0]   m_q;       // scaled argument
	logic [tfl_pkg::LOG_W-1:0]   acc_q;     // decade plus fraction, Q8.24
	logic                        zero_q;    // argument was zero
	logic [3:0]                  rem_q;     // divide-by-ten remainder
	logic [2:0]                  dcnt_q;    // byte counter of a division
	logic [tfl_pkg::C_W-1:0]     c_q;       // running product
	logic [tfl_pkg::STAGE_W-1:0] stage_q;
	logic [33:0]                 pl_q;      // low partial product >> 30

	logic [31:0] log_q;
	logic        stat_q;
	logic        ovalid_q;

	// decade compares
	logic above_ten, below_one;
	assign above_ten = (m_q > tfl_pkg::TEN_Q32);
	assign below_one = (m_q < tfl_pkg::ONE_Q32);

	// one quotient byte of m / 10 per cycle, MSB first
	logic [11:0] dv_t;
	logic [24:0] dv_prod;
	logic [7:0]  dv_q8;
	logic [11:0] dv_rem;
	assign dv_t    = {rem_q, m_q[63:56]};
	assign dv_prod = 25'(dv_t) * 25'(tfl_pkg::DIV10_RECIP);
	assign dv_q8   = dv_prod[23:16];
	assign dv_rem  = dv_t - 12'(12'(dv_q8) * tfl_pkg::DIV10_CONST);

	// shared multiplier: low word of c in ST_MLO, high bits in ST_MHI
	logic        mul_en;
	logic [31:0] mul_a;
	logic [31:0] factor;
	logic [63:0] mul_p;
	assign factor = tfl_pkg::stage_factor(stage_q);
	assign mul_en = (state_q == tfl_pkg::ST_MLO) || (state_q == tfl_pkg::ST_MHI);
	assign mul_a  = (state_q == tfl_pkg::ST_MLO) ? c_q[31:0] : 32'(c_q[35:32]);

	tfl_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (factor),
		.p   (mul_p)
	);

	// trial product: (hi*f << 2) + (lo*f >> 30)
	logic [37:0] trial;
	logic        trial_ok;
	assign trial    = 38'({mul_p[35:0], 2'b00}) + 38'(pl_q);
	assign trial_ok = (64'(trial) <= m_q);

	logic out_free;
	assign out_free = !ovalid_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tfl_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = (s_axis_tdata == '0) ? tfl_pkg::ST_OUT : tfl_pkg::ST_CHK;
				end
			end
			tfl_pkg::ST_CHK: begin
				if (above_ten) begin
					state_d = tfl_pkg::ST_DIV;
				end else if (!below_one) begin
					state_d = tfl_pkg::ST_MLO;
				end
			end
			tfl_pkg::ST_DIV: begin
				if (dcnt_q == 3'd7) begin
					state_d = tfl_pkg::ST_CHK;
				end
			end
			tfl_pkg::ST_MLO: state_d = tfl_pkg::ST_MHI;
			tfl_pkg::ST_MHI: state_d = tfl_pkg::ST_CMP;
			tfl_pkg::ST_CMP: begin
				if (trial_ok || stage_q != STAGE_LAST) begin
					state_d = tfl_pkg::ST_MLO;
				end else begin
					state_d = tfl_pkg::ST_OUT;
				end
			end
			tfl_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = tfl_pkg::ST_IDLE;
				end
			end
			default: state_d = tfl_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			tfl_pkg::ST_IDLE: begin
				m_q    <= s_axis_tdata;
				acc_q  <= '0;
				zero_q <= (s_axis_tdata == '0);
			end
			tfl_pkg::ST_CHK: begin
				if (above_ten) begin
					rem_q  <= '0;
					dcnt_q <= '0;
					acc_q  <= acc_q + tfl_pkg::DECADE_STEP;
				end else if (below_one) begin
					// m < 1, so m*10 cannot overflow
					m_q   <= (m_q << 3) + (m_q << 1);
					acc_q <= acc_q - tfl_pkg::DECADE_STEP;
				end else begin
					c_q     <= tfl_pkg::C_W'(tfl_pkg::ONE_Q32);
					stage_q <= '0;
				end
			end
			tfl_pkg::ST_DIV: begin
				m_q    <= {m_q[55:0], dv_q8};
				rem_q  <= dv_rem[3:0];
				dcnt_q <= dcnt_q + 3'd1;
			end
			tfl_pkg::ST_MHI: begin
				pl_q <= mul_p[63:30];
			end
			tfl_pkg::ST_CMP: begin
				if (trial_ok) begin
					c_q   <= trial[tfl_pkg::C_W-1:0];
					acc_q <= acc_q + 32'(tfl_pkg::stage_log(stage_q));
				end else begin
					stage_q <= stage_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == tfl_pkg::ST_OUT && out_free) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tfl_pkg::ST_OUT && out_free) begin
			log_q  <= zero_q ? '0 : acc_q;
			stat_q <= zero_q;
		end
	end

	assign s_axis_tready = (state_q == tfl_pkg::ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = log_q;
	assign m_axis_tuser  = stat_q;

endmodule

// ===== tb/log10_checker.sv =====
`timescale 1ns / 1ps

// Watches both streams of table_factor_log10, predicts each result and compares.
module log10_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      arg_valid,
	input  logic                      arg_ready,
	input  logic [tfl_pkg::ARG_W-1:0] arg_data,
	input  logic                      res_valid,
	input  logic                      res_ready,
	input  logic [tfl_pkg::LOG_W-1:0] res_data,
	input  logic                      res_err,
	output int                        fail_count,
	output int                        pending,
	output int                        checked
);

	typedef struct packed {
		logic [tfl_pkg::LOG_W-1:0] log_q824;
		logic                      zero_arg;
	} log_res_t;

	typedef struct packed {
		logic [tfl_pkg::ARG_W-1:0] arg;
		log_res_t                  want;
	} log_job_t;

	localparam int N_STAGES = (tfl_pkg::FACTOR_STAGES_DEF > tfl_pkg::TABLE_LEN) ?
		tfl_pkg::TABLE_LEN : tfl_pkg::FACTOR_STAGES_DEF;

	// Q2.30 factors 2, 1.1, 1.01, ...; entry 0 is the rightmost
	localparam logic [7:0][31:0] FACTOR_Q30 = {
		32'd1073741931, 32'd1073742898, 32'd1073752561, 32'd1073849198,
		32'd1074815566, 32'd1084479242, 32'd1181116006, 32'd2147483648
	};

	// log10 of each factor, Q8.24
	localparam logic [7:0][22:0] FLOG_Q24 = {
		23'd1, 23'd7, 23'd73, 23'd729, 23'd7283, 23'd72501, 23'd694454, 23'd5050445
	};

	// Q32.32 times Q2.30, truncated back to Q32.32
	function automatic logic [63:0] times_factor(input logic [63:0] c, input logic [31:0] f);
		logic [63:0] hi_prod;
		logic [63:0] lo_prod;
		hi_prod = {32'd0, c[63:32]} * {32'd0, f};
		lo_prod = {32'd0, c[31:0]} * {32'd0, f};
		return (hi_prod << 2) + (lo_prod >> 30);
	endfunction

	function automatic log_res_t predict_log10(input logic [tfl_pkg::ARG_W-1:0] arg);
		log_res_t    r;
		logic [63:0] mant;
		logic [63:0] prod;
		logic [63:0] last_ok;
		longint      decade;
		longint      frac;
		longint      cnt;
		longint      total;
		r = '0;
		if (arg == '0) begin
			r.zero_arg = 1'b1;
			return r;
		end
		mant   = arg;
		decade = 0;
		frac   = 0;
		prod   = tfl_pkg::ONE_Q32;
		// bring the mantissa into [1,10]; exactly ten is left alone
		if (mant >= tfl_pkg::TEN_Q32) begin
			while (mant > tfl_pkg::TEN_Q32) begin
				mant = mant / 64'd10;
				decade++;
			end
		end else if (mant <= tfl_pkg::ONE_Q32) begin
			while (mant < tfl_pkg::ONE_Q32) begin
				mant = mant * 64'd10;
				decade--;
			end
		end
		for (int st = 0; st < N_STAGES; st++) begin
			cnt     = 0;
			last_ok = prod;
			while (prod <= mant) begin
				cnt++;
				last_ok = prod;
				prod    = times_factor(prod, FACTOR_Q30[st]);
			end
			if (cnt > 0)
				cnt--;
			prod = last_ok;
			frac += cnt * longint'(FLOG_Q24[st]);
		end
		total      = decade * (longint'(1) << 24) + frac;
		r.log_q824 = total[tfl_pkg::LOG_W-1:0];
		return r;
	endfunction

	log_job_t jobs [$];
	int       errs;
	int       n_checked;

	always @(posedge clk or negedge arst_n) begin : watch
		log_job_t job;
		if (!arst_n) begin
			jobs.delete();
			errs       = 0;
			n_checked  = 0;
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
		end else begin
			if (arg_valid && arg_ready)
				jobs.push_back('{arg: arg_data, want: predict_log10(arg_data)});
			if (res_valid && res_ready) begin
				if (jobs.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%t: unexpected result log %h status %b", $realtime,
							res_data, res_err);
				end else begin
					job = jobs.pop_front();
					n_checked++;
					if (res_data !== job.want.log_q824 || res_err !== job.want.zero_arg) begin
						errs++;
						if (errs <= 10)
							$display({"%t: arg %h: got log %h (%0d) status %b, ",
								"want log %h (%0d) status %b"},
								$realtime, job.arg, res_data, $signed(res_data), res_err,
								job.want.log_q824, $signed(job.want.log_q824),
								job.want.zero_arg);
					end
				end
			end
			fail_count <= errs;
			pending    <= jobs.size();
			checked    <= n_checked;
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for table_factor_log10. The checker beside the block does all the
// predicting; this module only feeds arguments, throttles the result side and decides.
module tb_top;

	localparam int N_RANDOM = 680;

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [tfl_pkg::ARG_W-1:0] s_axis_tdata  = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [tfl_pkg::LOG_W-1:0] m_axis_tdata;
	logic                      m_axis_tuser;

	int fail_count;
	int pending;
	int checked;
	int n_sent    = 0;
	int rcv_stall = 0;

	// per-side idle enables; switched per chunk of the random part, off near the end
	bit snd_idle = 1'b1;
	bit rcv_idle = 1'b1;

	always #6 clk = ~clk;

	table_factor_log10 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),    // [63:0] arg_value
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),    // [31:0] log_result
		.m_axis_tuser  (m_axis_tuser)     // [0] status
	);

	log10_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.arg_valid  (s_axis_tvalid),
		.arg_ready  (s_axis_tready),
		.arg_data   (s_axis_tdata),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_data   (m_axis_tdata),
		.res_err    (m_axis_tuser),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	// Result side: ready drops in bursts of random length, started only while rcv_idle is set.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rcv_stall > 0) begin
			rcv_stall--;
			m_axis_tready <= 1'b0;
		end else if (rcv_idle && $urandom_range(0, 5) == 0) begin
			rcv_stall = $urandom_range(1, 10) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// 10^k in Q32.32, k = 0..9
	function automatic logic [tfl_pkg::ARG_W-1:0] pow10_q32(input int k);
		logic [tfl_pkg::ARG_W-1:0] v;
		v = tfl_pkg::ONE_Q32;
		repeat (k) v = v * 64'd10;
		return v;
	endfunction

	// Random argument: full-range patterns, log-uniform magnitudes, neighborhoods of one
	// and of the powers of ten (both signs of the exponent), tiny raw values, and zero.
	function automatic logic [tfl_pkg::ARG_W-1:0] rand_arg();
		logic [tfl_pkg::ARG_W-1:0] v;
		logic [tfl_pkg::ARG_W-1:0] base;
		int                        sel;
		sel = $urandom_range(0, 29);
		if (sel == 0) begin
			v = '0;
		end else if (sel <= 9) begin
			v = {$urandom, $urandom};
		end else if (sel <= 17) begin
			v = {$urandom, $urandom} >> $urandom_range(0, 63);
		end else if (sel <= 21) begin
			v = tfl_pkg::ONE_Q32 - 64'd1000 + 64'($urandom_range(0, 2000));
		end else if (sel <= 26) begin
			base = pow10_q32($urandom_range(0, 9));
			if ($urandom_range(0, 1))
				base = tfl_pkg::ONE_Q32 / (base >> 32);  // reciprocal decade
			v = base + 64'($urandom_range(0, 8));
			if (v > 64'd4)
				v = v - 64'd4;
		end else begin
			v = 64'($urandom_range(1, 100000));
		end
		return v;
	endfunction

	// Present one item and hold it until taken. valid stays high into the next call
	// unless that call opens a gap, so it never gets two assignments in one step.
	task automatic send_arg(input logic [tfl_pkg::ARG_W-1:0] v);
		if (snd_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= v;
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	// The checker's counter is registered, so look only after the next edge.
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [tfl_pkg::ARG_W-1:0] dir_args [$] = '{
			64'h0000_0000_0000_0000,   // zero: status set
			64'h0000_0000_0000_0001,   // smallest, ten multiplications by ten
			64'hFFFF_FFFF_FFFF_FFFF,   // largest
			64'h8000_0000_0000_0000,
			64'h0000_0001_0000_0000,   // exactly one
			64'h0000_0001_0000_0001,
			64'h0000_0000_FFFF_FFFF,
			64'h0000_000A_0000_0000,   // exactly ten: not scaled
			64'h0000_000A_0000_0001,
			64'h0000_0009_FFFF_FFFF,
			64'h0000_0002_0000_0000,
			64'h0000_0064_0000_0000,   // 100
			64'h3B9A_CA00_0000_0000,   // 1e9
			64'h0000_0000_8000_0000,   // 0.5
			64'h0000_0000_1999_999A,   // about 0.1
			64'h0000_0000_0000_FFFF,
			64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555,
			64'h0000_0003_0000_0000,
			64'h0000_0000_0000_0000    // zero again
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_args[i])
			send_arg(dir_args[i]);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 50 == 0) begin
				snd_idle = ($urandom_range(0, 3) != 0);
				rcv_idle = ($urandom_range(0, 3) != 0);
			end
			if (n >= N_RANDOM - 60) begin
				snd_idle = 1'b0;
				rcv_idle = 1'b0;
			end
			// once mid-run: hold off until the block has handed back everything
			if (n == N_RANDOM / 2) begin
				s_axis_tvalid <= 1'b0;
				wait_drained();
			end
			send_arg(rand_arg());
		end
		s_axis_tvalid <= 1'b0;

		wait_drained();
		repeat (300) @(posedge clk);

		$display("Sent %0d arguments (%0d directed: zero, one, ten, decade edges, full scale),",
			n_sent, dir_args.size());
		$display("then random magnitudes under sender and receiver stalls; %0d results checked.",
			checked);
		if (pending != 0)
			$display("%0d results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#18_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tfl_pkg.sv
rtl/tfl_mul.sv
rtl/table_factor_log10.sv
tb/log10_checker.sv
tb/tb_top.sv
